### rtl/ilef_pkg.sv
package ilef_pkg;

    // field widths
    localparam int DATA_W    = 16;
    localparam int YAW_W     = 24;
    localparam int CFG_IDX_W = 3;

    // divider geometry: quotient never exceeds 32768 for either ratio
    localparam int QUO_W     = 17;
    localparam int LAT_NUM_W = 32;
    localparam int LAT_DEN_W = 17;
    localparam int FWD_NUM_W = 48;
    localparam int FWD_DEN_W = 35;

    // register reset values
    localparam logic [DATA_W-1:0] FORWARD_WEIGHT_RST  = 16'd1024;
    localparam logic [DATA_W-1:0] LATERAL_WEIGHT_RST  = 16'd4096;
    localparam logic [DATA_W-1:0] RATIO_BIAS_RST      = 16'd1536;
    localparam logic [DATA_W-1:0] GATE_HALF_POINT_RST = 16'd2560;
    localparam logic [DATA_W-1:0] TURN_GAIN_RST       = 16'd2540;
    localparam logic [DATA_W-1:0] CRUISE_SPEED_RST    = 16'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FORWARD_WEIGHT  = 3'd0,
        CFG_LATERAL_WEIGHT  = 3'd1,
        CFG_RATIO_BIAS      = 3'd2,
        CFG_GATE_HALF_POINT = 3'd3,
        CFG_TURN_GAIN       = 3'd4,
        CFG_CRUISE_SPEED    = 3'd5
    } cfg_reg_t;

    // sign and zero-divisor flags that ride along with a quotient
    typedef struct packed {
        logic neg;
        logic zero;
    } sign_tag_t;

    localparam int TAG_W = $bits(sign_tag_t);

endpackage

### rtl/inductor_line_error_fusion_core.sv
// Line-error fusion for four inductor channels. Each request carries four
// unsigned Q10.6 strengths; the block returns one result per request: the
// lateral ratio (a-d)/(a+d), the gated forward ratio
// (b-c)*m/((b+c+ratio_bias)*(m+gate_half_point)) with m = max(b,c), their
// weighted fusion as fused_error, yaw_rate = turn_gain * fused_error, and the
// configured cruise speed. All quotients and shifts round to nearest with
// ties away from zero and every field saturates to its format; a zero
// divisor gives a zero ratio. The datapath is a 26-stage pipeline: three
// stages of operand prep, multiply and numerator build, two 17-stage
// restoring dividers running side by side (one quotient bit per stage), then
// six stages of saturation, weighting, fusion and yaw scaling. A request is
// taken every cycle unless sample_stall is high; empty stages collapse so
// requests keep entering while a finished result is stalled at the output.
// Users must write registers through cfg_we/cfg_index/cfg_data only while no
// request is in flight, not enforced by the block; writes past index 5 drop.
module inductor_line_error_fusion_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration
    input  logic                                  cfg_we,
    input  logic [ilef_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ilef_pkg::DATA_W-1:0]           cfg_data,
    // request side
    input  logic                                  sample_valid,
    output logic                                  sample_stall,
    input  logic [ilef_pkg::DATA_W-1:0]           chan_a,
    input  logic [ilef_pkg::DATA_W-1:0]           chan_b,
    input  logic [ilef_pkg::DATA_W-1:0]           chan_c,
    input  logic [ilef_pkg::DATA_W-1:0]           chan_d,
    // result side
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output logic signed [ilef_pkg::DATA_W-1:0]    forward_error,
    output logic signed [ilef_pkg::DATA_W-1:0]    lateral_error,
    output logic signed [ilef_pkg::DATA_W-1:0]    fused_error,
    output logic signed [ilef_pkg::DATA_W-1:0]    speed_out,
    output logic signed [ilef_pkg::YAW_W-1:0]     yaw_rate
);

    localparam int QW       = ilef_pkg::QUO_W;
    // stage map
    localparam int ST_PREP  = 0;
    localparam int ST_MUL   = 1;
    localparam int ST_NUM   = 2;
    localparam int ST_DIV0  = 3;
    localparam int ST_SAT   = ST_DIV0 + QW;
    localparam int ST_WPROD = ST_SAT + 1;
    localparam int ST_FSUM  = ST_SAT + 2;
    localparam int ST_LINE  = ST_SAT + 3;
    localparam int ST_YPROD = ST_SAT + 4;
    localparam int ST_YAW   = ST_SAT + 5;
    localparam int NS       = ST_YAW + 1;

    // round to nearest, ties away from zero, by a right shift
    function automatic logic signed [33:0] round_shift(input logic signed [33:0] v,
                                                        input int sh);
        logic        neg;
        logic [33:0] mag;
        logic [33:0] r;
        neg = v[33];
        mag = neg ? 34'(-v) : 34'(v);
        r   = (mag + (34'd1 << (sh - 1))) >> sh;
        return neg ? -$signed(r) : $signed(r);
    endfunction

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [15:0] forward_weight_reg;
    logic [15:0] lateral_weight_reg;
    logic [15:0] ratio_bias_reg;
    logic [15:0] gate_half_point_reg;
    logic [15:0] turn_gain_reg;
    logic [15:0] cruise_speed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            forward_weight_reg  <= ilef_pkg::FORWARD_WEIGHT_RST;
            lateral_weight_reg  <= ilef_pkg::LATERAL_WEIGHT_RST;
            ratio_bias_reg      <= ilef_pkg::RATIO_BIAS_RST;
            gate_half_point_reg <= ilef_pkg::GATE_HALF_POINT_RST;
            turn_gain_reg       <= ilef_pkg::TURN_GAIN_RST;
            cruise_speed_reg    <= ilef_pkg::CRUISE_SPEED_RST;
        end
        else if (cfg_we)
        begin
            unique case (ilef_pkg::cfg_reg_t'(cfg_index))
                ilef_pkg::CFG_FORWARD_WEIGHT:  forward_weight_reg  <= cfg_data;
                ilef_pkg::CFG_LATERAL_WEIGHT:  lateral_weight_reg  <= cfg_data;
                ilef_pkg::CFG_RATIO_BIAS:      ratio_bias_reg      <= cfg_data;
                ilef_pkg::CFG_GATE_HALF_POINT: gate_half_point_reg <= cfg_data;
                ilef_pkg::CFG_TURN_GAIN:       turn_gain_reg       <= cfg_data;
                ilef_pkg::CFG_CRUISE_SPEED:    cruise_speed_reg    <= cfg_data;
                default:                       ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // pipeline control: a stage loads when it is empty or its
    // successor loads, so bubbles collapse under an output stall
    // ---------------------------------------------------------------
    logic [NS:0]   adv;
    logic [NS-1:0] v_reg;
    logic [NS-1:0] v_next;

    assign adv[NS] = !result_stall;

    genvar i;
    generate
        for (i = 0; i < NS; i++) begin : g_ctl
            assign adv[i] = !v_reg[i] || adv[i+1];
            if (i == 0) begin : g_head
                assign v_next[i] = adv[i] ? sample_valid : v_reg[i];
            end
            else begin : g_body
                assign v_next[i] = adv[i] ? v_reg[i-1] : v_reg[i];
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign sample_stall = !adv[0];
    assign result_valid = v_reg[NS-1];

    // ---------------------------------------------------------------
    // prep: differences, sums, larger inner channel
    // ---------------------------------------------------------------
    logic [15:0] lat_mag_reg;
    logic        lat_neg_reg;
    logic [16:0] lat_sum_reg;
    logic [15:0] fwd_mag_reg;
    logic        fwd_neg_reg;
    logic [15:0] inner_max_reg;
    logic [17:0] den1_reg;
    logic [16:0] den2_reg;

    logic [15:0] inner_max;
    assign inner_max = (chan_b > chan_c) ? chan_b : chan_c;

    always_ff @(posedge clk)
    begin
        if (adv[ST_PREP])
        begin
            lat_neg_reg   <= chan_a < chan_d;
            lat_mag_reg   <= (chan_a < chan_d) ? chan_d - chan_a : chan_a - chan_d;
            lat_sum_reg   <= 17'(chan_a) + 17'(chan_d);
            fwd_neg_reg   <= chan_b < chan_c;
            fwd_mag_reg   <= (chan_b < chan_c) ? chan_c - chan_b : chan_b - chan_c;
            inner_max_reg <= inner_max;
            den1_reg      <= 18'(chan_b) + 18'(chan_c) + 18'(ratio_bias_reg);
            den2_reg      <= 17'(inner_max) + 17'(gate_half_point_reg);
        end
    end

    // ---------------------------------------------------------------
    // multiply: forward numerator and divisor products
    // ---------------------------------------------------------------
    logic [31:0]                     fwd_prod_reg;
    logic [ilef_pkg::FWD_DEN_W-1:0]  fwd_den_mul_reg;
    logic                            fwd_neg_mul_reg;
    logic [ilef_pkg::LAT_NUM_W-1:0]  lat_num_mul_reg;
    logic [ilef_pkg::LAT_DEN_W-1:0]  lat_den_mul_reg;
    logic                            lat_neg_mul_reg;

    always_ff @(posedge clk)
    begin
        if (adv[ST_MUL])
        begin
            fwd_prod_reg    <= 32'(fwd_mag_reg) * 32'(inner_max_reg);
            fwd_den_mul_reg <= 35'(den1_reg) * 35'(den2_reg);
            fwd_neg_mul_reg <= fwd_neg_reg;
            // half the divisor added up front gives round-half-up
            lat_num_mul_reg <= {1'b0, lat_mag_reg, 15'd0} + 32'(lat_sum_reg >> 1);
            lat_den_mul_reg <= lat_sum_reg;
            lat_neg_mul_reg <= lat_neg_reg;
        end
    end

    // ---------------------------------------------------------------
    // numerators ready for the dividers
    // ---------------------------------------------------------------
    logic [ilef_pkg::FWD_NUM_W-1:0]  fwd_num_reg;
    logic [ilef_pkg::FWD_DEN_W-1:0]  fwd_den_reg;
    ilef_pkg::sign_tag_t             fwd_tag_reg;
    logic [ilef_pkg::LAT_NUM_W-1:0]  lat_num_reg;
    logic [ilef_pkg::LAT_DEN_W-1:0]  lat_den_reg;
    ilef_pkg::sign_tag_t             lat_tag_reg;

    always_ff @(posedge clk)
    begin
        if (adv[ST_NUM])
        begin
            fwd_num_reg      <= {1'b0, fwd_prod_reg, 15'd0} + 48'(fwd_den_mul_reg >> 1);
            fwd_den_reg      <= fwd_den_mul_reg;
            fwd_tag_reg.neg  <= fwd_neg_mul_reg;
            fwd_tag_reg.zero <= fwd_den_mul_reg == '0;
            lat_num_reg      <= lat_num_mul_reg;
            lat_den_reg      <= lat_den_mul_reg;
            lat_tag_reg.neg  <= lat_neg_mul_reg;
            lat_tag_reg.zero <= lat_den_mul_reg == '0;
        end
    end

    // ---------------------------------------------------------------
    // dividers, one quotient bit per stage
    // ---------------------------------------------------------------
    logic [QW-1:0]       lat_quo;
    logic [QW-1:0]       fwd_quo;
    ilef_pkg::sign_tag_t lat_tag_out;
    ilef_pkg::sign_tag_t fwd_tag_out;

    ilef_div #(
        .NUM_W (ilef_pkg::LAT_NUM_W),
        .DEN_W (ilef_pkg::LAT_DEN_W),
        .QUO_W (QW),
        .TAG_W (ilef_pkg::TAG_W)
    ) u_lat_div (
        .clk     (clk),
        .adv     (adv[ST_DIV0 +: QW]),
        .num     (lat_num_reg),
        .den     (lat_den_reg),
        .tag_in  (lat_tag_reg),
        .quo     (lat_quo),
        .tag_out (lat_tag_out)
    );

    ilef_div #(
        .NUM_W (ilef_pkg::FWD_NUM_W),
        .DEN_W (ilef_pkg::FWD_DEN_W),
        .QUO_W (QW),
        .TAG_W (ilef_pkg::TAG_W)
    ) u_fwd_div (
        .clk     (clk),
        .adv     (adv[ST_DIV0 +: QW]),
        .num     (fwd_num_reg),
        .den     (fwd_den_reg),
        .tag_in  (fwd_tag_reg),
        .quo     (fwd_quo),
        .tag_out (fwd_tag_out)
    );

    // ---------------------------------------------------------------
    // apply sign, saturate, zero divisor override
    // ---------------------------------------------------------------
    logic signed [15:0] lat_err_next;
    logic signed [15:0] fwd_err_next;

    always_comb
    begin
        // quotient is at most 32768: only the positive side can overflow
        if (lat_tag_out.zero)
            lat_err_next = '0;
        else if (lat_tag_out.neg)
            lat_err_next = 16'(-$signed({1'b0, lat_quo}));
        else if (lat_quo > 17'd32767)
            lat_err_next = 16'sd32767;
        else
            lat_err_next = 16'(lat_quo);

        if (fwd_tag_out.zero)
            fwd_err_next = '0;
        else if (fwd_tag_out.neg)
            fwd_err_next = 16'(-$signed({1'b0, fwd_quo}));
        else if (fwd_quo > 17'd32767)
            fwd_err_next = 16'sd32767;
        else
            fwd_err_next = 16'(fwd_quo);
    end

    logic signed [15:0] lat_err_reg   [ST_SAT:ST_YAW];
    logic signed [15:0] fwd_err_reg   [ST_SAT:ST_YAW];

    always_ff @(posedge clk)
    begin
        if (adv[ST_SAT])
        begin
            lat_err_reg[ST_SAT] <= lat_err_next;
            fwd_err_reg[ST_SAT] <= fwd_err_next;
        end
    end

    generate
        for (i = ST_SAT + 1; i <= ST_YAW; i++) begin : g_err_carry
            always_ff @(posedge clk)
            begin
                if (adv[i])
                begin
                    lat_err_reg[i] <= lat_err_reg[i-1];
                    fwd_err_reg[i] <= fwd_err_reg[i-1];
                end
            end
        end
    endgenerate

    // ---------------------------------------------------------------
    // weighting, fusion, yaw scaling
    // ---------------------------------------------------------------
    logic signed [32:0] lat_wprod_reg;
    logic signed [32:0] fwd_wprod_reg;
    logic signed [33:0] fuse_sum_reg;
    logic signed [15:0] line_reg      [ST_LINE:ST_YAW];
    logic signed [32:0] yaw_prod_reg;
    logic signed [23:0] yaw_reg;

    logic signed [33:0] line_round;
    logic signed [33:0] yaw_round;

    assign line_round = round_shift(fuse_sum_reg, 15);
    assign yaw_round  = round_shift(34'(yaw_prod_reg), 12);

    always_ff @(posedge clk)
    begin
        if (adv[ST_WPROD])
        begin
            lat_wprod_reg <= 33'(lat_err_reg[ST_SAT]) * $signed({1'b0, lateral_weight_reg});
            fwd_wprod_reg <= 33'(fwd_err_reg[ST_SAT]) * $signed({1'b0, forward_weight_reg});
        end
        if (adv[ST_FSUM])
            fuse_sum_reg <= 34'(lat_wprod_reg) + 34'(fwd_wprod_reg);
        if (adv[ST_LINE])
        begin
            if (line_round > 34'sd32767)
                line_reg[ST_LINE] <= 16'sd32767;
            else if (line_round < -34'sd32768)
                line_reg[ST_LINE] <= -16'sd32768;
            else
                line_reg[ST_LINE] <= 16'(line_round);
        end
        if (adv[ST_YPROD])
        begin
            yaw_prod_reg         <= 33'(line_reg[ST_LINE]) * $signed({1'b0, turn_gain_reg});
            line_reg[ST_YPROD]   <= line_reg[ST_LINE];
        end
        if (adv[ST_YAW])
        begin
            line_reg[ST_YAW] <= line_reg[ST_YPROD];
            if (yaw_round > 34'sd8388607)
                yaw_reg <= 24'sd8388607;
            else if (yaw_round < -34'sd8388608)
                yaw_reg <= -24'sd8388608;
            else
                yaw_reg <= 24'(yaw_round);
        end
    end

    assign forward_error = fwd_err_reg[ST_YAW];
    assign lateral_error = lat_err_reg[ST_YAW];
    assign fused_error   = line_reg[ST_YAW];
    assign speed_out     = cruise_speed_reg;
    assign yaw_rate      = yaw_reg;

`ifndef ASSERT_OFF
    // input is held off only when the first stage is occupied
    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> v_reg[ST_PREP])
        else $error("request stalled with an empty first stage");

    // ratios are bounded by one, so the quotient never passes 32768
    a_lat_quo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[ST_SAT-1] && !lat_tag_out.zero) |-> (lat_quo <= 17'd32768))
        else $error("lateral quotient out of range");

    a_fwd_quo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[ST_SAT-1] && !fwd_tag_out.zero) |-> (fwd_quo <= 17'd32768))
        else $error("forward quotient out of range");

    // a held result keeps the last stage occupied
    a_last_stage_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> v_reg[NS-1])
        else $error("stalled result dropped from last stage");
`endif

endmodule

### rtl/ilef_div.sv
module ilef_div #(
    parameter int NUM_W = ilef_pkg::LAT_NUM_W,
    parameter int DEN_W = ilef_pkg::LAT_DEN_W,
    parameter int QUO_W = ilef_pkg::QUO_W,
    parameter int TAG_W = ilef_pkg::TAG_W
) (
    input  logic             clk,
    input  logic [QUO_W-1:0] adv,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [TAG_W-1:0] tag_in,
    output logic [QUO_W-1:0] quo,
    output logic [TAG_W-1:0] tag_out
);

    // remainder wide enough for the divisor shifted by the top quotient bit
    localparam int REM_W = ((NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W) + 1;

    logic [REM_W-1:0] rem_reg [QUO_W];
    logic [DEN_W-1:0] den_reg [QUO_W];
    logic [QUO_W-1:0] quo_reg [QUO_W];
    logic [TAG_W-1:0] tag_reg [QUO_W];

    genvar k;
    generate
        for (k = 0; k < QUO_W; k++) begin : g_step
            logic [REM_W-1:0] rem_prev;
            logic [DEN_W-1:0] den_prev;
            logic [QUO_W-1:0] quo_prev;
            logic [TAG_W-1:0] tag_prev;
            logic [REM_W-1:0] den_shift;
            logic [REM_W:0]   diff;
            logic             bit_set;
            logic [REM_W-1:0] rem_next;
            logic [QUO_W-1:0] quo_next;

            if (k == 0) begin : g_first
                assign rem_prev = REM_W'(num);
                assign den_prev = den;
                assign quo_prev = '0;
                assign tag_prev = tag_in;
            end
            else begin : g_rest
                assign rem_prev = rem_reg[k-1];
                assign den_prev = den_reg[k-1];
                assign quo_prev = quo_reg[k-1];
                assign tag_prev = tag_reg[k-1];
            end

            // one restoring step, quotient bits from the top down
            assign den_shift = REM_W'(den_prev) << (QUO_W - 1 - k);
            assign diff      = {1'b0, rem_prev} - {1'b0, den_shift};
            assign bit_set   = !diff[REM_W];
            assign rem_next  = bit_set ? diff[REM_W-1:0] : rem_prev;
            assign quo_next  = {quo_prev[QUO_W-2:0], bit_set};

            always_ff @(posedge clk)
            begin
                if (adv[k])
                begin
                    rem_reg[k] <= rem_next;
                    den_reg[k] <= den_prev;
                    quo_reg[k] <= quo_next;
                    tag_reg[k] <= tag_prev;
                end
            end
        end
    endgenerate

    assign quo     = quo_reg[QUO_W-1];
    assign tag_out = tag_reg[QUO_W-1];

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int DATA_W    = ilef_pkg::DATA_W;
    localparam int YAW_W     = ilef_pkg::YAW_W;
    localparam int CFG_IDX_W = ilef_pkg::CFG_IDX_W;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                      cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [DATA_W-1:0]         cfg_data = '0;

    logic                      sample_valid = 1'b0;
    logic                      sample_stall;
    logic [DATA_W-1:0]         chan_a = '0, chan_b = '0, chan_c = '0, chan_d = '0;

    logic                      result_valid;
    logic                      result_stall = 1'b0;
    logic signed [DATA_W-1:0]  forward_error, lateral_error, fused_error, speed_out;
    logic signed [YAW_W-1:0]   yaw_rate;

    inductor_line_error_fusion_core dut (.*);

    always #2 clk = ~clk;

    // one request and one result
    typedef struct packed {
        logic [DATA_W-1:0] a, b, c, d;
    } sample_t;

    typedef struct packed {
        logic [DATA_W-1:0] fwd, lat, line, speed;
        logic [YAW_W-1:0]  yaw;
    } fusion_t;

    // shadow copy of the registers
    logic [DATA_W-1:0] w_fwd, w_lat, bias, half_pt, gain, speed_reg;

    sample_t pending_samples[$];
    fusion_t expected_fusion[$];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  hold_cycles = 0;
    bit  hold_req = 1'b0;
    int  errors = 0;

    // round to nearest, ties away from zero; zero divisor gives zero
    function automatic longint round_div(longint num, longint den);
        longint mag;
        longint q;
        if (den == 0)
            return 0;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint clamp(longint v, int bits);
        longint hi;
        hi = (longint'(1) << (bits - 1)) - 1;
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    function automatic fusion_t fuse_sample(sample_t s);
        longint a, b, c, d, m, den1, den2, lat, fwd, line, yaw;
        fusion_t r;
        a = longint'(s.a); b = longint'(s.b); c = longint'(s.c); d = longint'(s.d);
        m = (b > c) ? b : c;
        den1 = b + c + longint'(bias);
        den2 = m + longint'(half_pt);
        lat = 0;
        fwd = 0;
        // zero outer sum leaves the lateral ratio at zero
        if (a + d != 0)
            lat = clamp(round_div((a - d) * 32768, a + d), 16);
        if (den1 != 0 && den2 != 0)
            fwd = clamp(round_div((b - c) * m * 32768, den1 * den2), 16);
        line = clamp(round_div(lat * longint'(w_lat) + fwd * longint'(w_fwd), 32768), 16);
        yaw = clamp(round_div(line * longint'(gain), 4096), 24);
        r.fwd = fwd[15:0];
        r.lat = lat[15:0];
        r.line = line[15:0];
        r.speed = speed_reg;
        r.yaw = yaw[23:0];
        return r;
    endfunction

    // driver: next request goes out when the current one is taken
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!sample_valid || !sample_stall)
            begin
                if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    sample_t s;
                    s = pending_samples.pop_front();
                    expected_fusion.push_back(fuse_sample(s));
                    chan_a <= s.a;
                    chan_b <= s.b;
                    chan_c <= s.c;
                    chan_d <= s.d;
                    sample_valid <= 1'b1;
                end
                else
                begin
                    sample_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall: long hold-off when asked, else random
    always @(posedge clk)
    begin
        if (hold_req && hold_cycles == 0)
            hold_cycles <= 400;
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // monitor: compare each taken result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_fusion.size() == 0)
            begin
                $display("%0t: unexpected result fwd=%h", $realtime, forward_error);
                errors <= errors + 1;
            end
            else
            begin
                fusion_t e;
                e = expected_fusion.pop_front();
                if (e.fwd !== forward_error || e.lat !== lateral_error ||
                    e.line !== fused_error || e.speed !== speed_out || e.yaw !== yaw_rate)
                begin
                    $display("%0t: mismatch expected fwd=%h lat=%h line=%h spd=%h yaw=%h",
                             $realtime, e.fwd, e.lat, e.line, e.speed, e.yaw);
                    $display("%0t:          actual fwd=%h lat=%h line=%h spd=%h yaw=%h",
                             $realtime, forward_error, lateral_error, fused_error,
                             speed_out, yaw_rate);
                    errors <= errors + 1;
                end
            end
        end
    end

    task automatic write_reg(ilef_pkg::cfg_reg_t idx, logic [DATA_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            ilef_pkg::CFG_FORWARD_WEIGHT:  w_fwd = val;
            ilef_pkg::CFG_LATERAL_WEIGHT:  w_lat = val;
            ilef_pkg::CFG_RATIO_BIAS:      bias = val;
            ilef_pkg::CFG_GATE_HALF_POINT: half_pt = val;
            ilef_pkg::CFG_TURN_GAIN:       gain = val;
            default:                       speed_reg = val;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_all(logic [DATA_W-1:0] fw, logic [DATA_W-1:0] lw,
                             logic [DATA_W-1:0] rb, logic [DATA_W-1:0] hp,
                             logic [DATA_W-1:0] tg, logic [DATA_W-1:0] sp);
        write_reg(ilef_pkg::CFG_FORWARD_WEIGHT, fw);
        write_reg(ilef_pkg::CFG_LATERAL_WEIGHT, lw);
        write_reg(ilef_pkg::CFG_RATIO_BIAS, rb);
        write_reg(ilef_pkg::CFG_GATE_HALF_POINT, hp);
        write_reg(ilef_pkg::CFG_TURN_GAIN, tg);
        write_reg(ilef_pkg::CFG_CRUISE_SPEED, sp);
    endtask

    task automatic queue_sample(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
                                logic [DATA_W-1:0] c, logic [DATA_W-1:0] d);
        sample_t s;
        s.a = a; s.b = b; s.c = c; s.d = d;
        pending_samples.push_back(s);
    endtask

    // random strength: mostly small, sometimes full range or an extreme
    function automatic logic [DATA_W-1:0] rand_chan();
        case ($urandom_range(5))
            0: return DATA_W'($urandom_range(65535));
            1: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
            2: return DATA_W'($urandom_range(255));
            default: return DATA_W'($urandom_range(8191));
        endcase
    endfunction

    task automatic drain();
        wait (pending_samples.size() == 0 && expected_fusion.size() == 0);
        repeat (40) @(posedge clk);
    endtask

    task automatic random_phase(int n);
        repeat (n)
            queue_sample(rand_chan(), rand_chan(), rand_chan(), rand_chan());
        drain();
    endtask

    initial
    begin
        w_fwd = ilef_pkg::FORWARD_WEIGHT_RST;
        w_lat = ilef_pkg::LATERAL_WEIGHT_RST;
        bias = ilef_pkg::RATIO_BIAS_RST;
        half_pt = ilef_pkg::GATE_HALF_POINT_RST;
        gain = ilef_pkg::TURN_GAIN_RST;
        speed_reg = ilef_pkg::CRUISE_SPEED_RST;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: extremes, zero sums, ratio of exactly one, balanced inputs
        queue_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        queue_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_sample(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
        queue_sample(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
        queue_sample(16'h0001, 16'h0001, 16'h0000, 16'h0000);
        queue_sample(16'h0000, 16'h0000, 16'h0001, 16'h0001);
        queue_sample(16'h0003, 16'h0040, 16'h0020, 16'h0001);
        queue_sample(16'h1234, 16'h0A00, 16'h0A00, 16'h1234);
        queue_sample(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
        drain();

        // zero bias and zero half point: all-zero forward divisor
        write_all(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h7FFF);
        queue_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        queue_sample(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
        queue_sample(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
        queue_sample(16'h0010, 16'h0001, 16'h0000, 16'h0008);
        drain();

        send_idle_pct = 21;
        recv_idle_pct = 77;
        write_all(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h8000);
        random_phase(60);
        write_all(ilef_pkg::FORWARD_WEIGHT_RST, ilef_pkg::LATERAL_WEIGHT_RST,
                  ilef_pkg::RATIO_BIAS_RST, ilef_pkg::GATE_HALF_POINT_RST,
                  ilef_pkg::TURN_GAIN_RST, 16'h0180);
        random_phase(120);

        send_idle_pct = 77;
        recv_idle_pct = 21;
        write_all(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'hFF00);
        random_phase(100);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_all(DATA_W'($urandom_range(65535)), DATA_W'($urandom_range(65535)),
                  DATA_W'($urandom_range(65535)), DATA_W'($urandom_range(65535)),
                  DATA_W'($urandom_range(65535)), DATA_W'($urandom_range(65535)));
        // long output hold-off while requests keep coming, so the pipe backs up
        hold_req = 1'b1;
        repeat (120)
            queue_sample(rand_chan(), rand_chan(), rand_chan(), rand_chan());
        wait (hold_cycles > 0);
        hold_req = 1'b0;
        drain();
        random_phase(100);

        if (errors == 0 && expected_fusion.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Verification failed");
        $finish;
    end
endmodule
